>>> sv/windowed_weight_statistics_top_macros.svh
// ----------------------------------------------------------------------------
// Windowed weight statistics - assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_WEIGHT_STATISTICS_TOP_MACROS_SVH
`define WINDOWED_WEIGHT_STATISTICS_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define WWS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wws check failed: same-cycle implication");

`define WWS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wws check failed: next-cycle implication");

`else

`define WWS_ASSERT_IMP(label, clk, rstn, ante, cons)

`define WWS_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> sv/wws_pkg.sv
// ----------------------------------------------------------------------------
// wws_pkg
// Shared widths, codes and types for the windowed weight statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package wws_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int VALUE_W       = 25;
    localparam int FILL_W        = 7;
    localparam int COUNT_W       = 32;
    localparam int MODE_W        = 2;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 144;
    localparam int DEPTH_DEFAULT = 100;

    localparam logic [MODE_W-1:0] MODE_KG     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TON    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TON_X2 = 2'd3;

    localparam logic OP_READING = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic int wws_addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

>>> sv/wws_window_ram.sv
// ----------------------------------------------------------------------------
// wws_window_ram
// Ring window store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wws_window_ram import wws_pkg::*; #(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  wire                                     aclk,
    input  wire                                     wr_en,
    input  wire  [wws_addr_width(WINDOW_DEPTH)-1:0] wr_addr,
    input  wire  [VALUE_W-1:0]                      wr_data,
    input  wire                                     rd_en,
    input  wire  [wws_addr_width(WINDOW_DEPTH)-1:0] rd_addr,
    output logic [VALUE_W-1:0]                      rd_data
);

    logic [VALUE_W-1:0] mem [WINDOW_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/wws_divider.sv
// ----------------------------------------------------------------------------
// wws_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wws_divider import wws_pkg::*; #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 7
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire  div_ctrl_t   ctrl,
    input  wire  [DVD_W-1:0]  dividend,
    input  wire  [DVS_W-1:0]  divisor,
    output div_stat_t         stat,
    output logic [DVD_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

    logic [DVD_W-1:0]  work_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign rem_sh = {rem_reg, work_reg[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= {work_reg[DVD_W-2:0], fits};
            rem_reg  <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

`default_nettype wire

>>> sv/windowed_weight_statistics_top.sv
// ----------------------------------------------------------------------------
// windowed_weight_statistics_top
// Mode-scaled weight readings into a ring window; min, max, mean per reading.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  s_      | in  | tuser op; tdata sample_value
//  m_      | out | tuser unit_is_ton; tdata shown, min, max, mean, fill, count
//  cfg_    | in  | scale_mode, taken on any cycle
//
//  A reading makes one registered read per window entry through the shared
//  compare/add step, then a one-bit-per-cycle divide of the window sum.
//  A clear beat gives no result.
//  s_tready is high only while the sequencer is idle; a waiting result beat
//  holds the next one back but not the next accept.
//  Reset is synchronous; no clearing pass, window entries need none.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_weight_statistics_top_macros.svh"

module windowed_weight_statistics_top import wws_pkg::*; #(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [S_TDATA_W-1:0]  s_tdata,   // [23:0] sample_value
    input  wire                   s_tuser,   // [0] op

    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [24:0] shown_value, [49:25] window_minimum,
                                             // [74:50] window_maximum, [99:75] window_mean,
                                             // [106:100] window_fill,
                                             // [138:107] reading_number, rest zero
    output logic                  m_tuser,   // [0] unit_is_ton

    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [MODE_W-1:0]     cfg_data
);

    localparam int PTR_W = wws_addr_width(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = VALUE_W + CNT_W;
    localparam int PAD_W = M_TDATA_W - 4 * VALUE_W - FILL_W - COUNT_W;

    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST_C = PTR_W'(WINDOW_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               dvalid_reg, dvalid_next;
    logic               first_reg, first_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    logic [VALUE_W-1:0] shown_reg;
    logic               ton_reg;
    logic [VALUE_W-1:0] lo_reg;
    logic [VALUE_W-1:0] hi_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               neg_reg;
    logic [VALUE_W-1:0] mean_reg;

    logic [VALUE_W-1:0] out_shown_reg;
    logic               out_ton_reg;
    logic [VALUE_W-1:0] out_lo_reg;
    logic [VALUE_W-1:0] out_hi_reg;
    logic [VALUE_W-1:0] out_mean_reg;
    logic [FILL_W-1:0]  out_fill_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               s_accept;
    logic               issue;
    logic               scan_done;
    logic               out_load;
    logic               wr_en;
    logic [VALUE_W-1:0] rd_data;
    logic [VALUE_W-1:0] sample_shown;
    logic [SUM_W-1:0]   rd_ext;
    logic [SUM_W-1:0]   sum_mag;
    logic [SUM_W-1:0]   quotient;
    logic [VALUE_W-1:0] q_mag;
    logic [FILL_W+CNT_W-1:0] fill_wide;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign sample_shown = (mode_reg == MODE_TON_X2) ? {s_tdata[SAMPLE_W-1:0], 1'b0}
                                                    : {s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-1:0]};

    assign wr_en     = (state_reg == ST_WRITE);
    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg != fill_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issue && !dvalid_reg;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign rd_ext  = {{CNT_W{rd_data[VALUE_W-1]}}, rd_data};
    assign sum_mag = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign q_mag   = quotient[VALUE_W-1:0];
    assign fill_wide = {{FILL_W{1'b0}}, fill_reg};

    assign div_ctrl.start = scan_done;

    wws_window_ram #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (shown_reg),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[PTR_W-1:0]),
        .rd_data (rd_data)
    );

    wws_divider #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (sum_mag),
        .divisor  (fill_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb begin
        state_next    = state_reg;
        mode_next     = cfg_valid ? cfg_data : mode_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        rd_cnt_next   = rd_cnt_reg;
        dvalid_next   = 1'b0;
        first_next    = first_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == OP_CLEAR) begin
                        wr_ptr_next = '0;
                        fill_next   = '0;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                wr_ptr_next = (wr_ptr_reg == PTR_LAST_C) ? '0 : wr_ptr_reg + 1'b1;
                fill_next   = (fill_reg == DEPTH_C) ? fill_reg : fill_reg + 1'b1;
                count_next  = count_reg + 1'b1;
                rd_cnt_next = '0;
                first_next  = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                dvalid_next = issue;
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (dvalid_reg) begin
                    first_next = 1'b0;
                end
                if (scan_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_KG;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            dvalid_reg   <= 1'b0;
            first_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            rd_cnt_reg   <= rd_cnt_next;
            dvalid_reg   <= dvalid_next;
            first_reg    <= first_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // shared compare/add step, one window entry per beat of read data
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            shown_reg <= sample_shown;
            ton_reg   <= (mode_reg != MODE_KG);
        end
        if (dvalid_reg) begin
            if (first_reg) begin
                lo_reg  <= rd_data;
                hi_reg  <= rd_data;
                sum_reg <= rd_ext;
            end else begin
                if ($signed(rd_data) < $signed(lo_reg)) begin
                    lo_reg <= rd_data;
                end
                if ($signed(rd_data) > $signed(hi_reg)) begin
                    hi_reg <= rd_data;
                end
                sum_reg <= sum_reg + rd_ext;
            end
        end
        if (scan_done) begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (div_stat.done) begin
            mean_reg <= neg_reg ? (~q_mag + 1'b1) : q_mag;
        end
        if (out_load) begin
            out_shown_reg <= shown_reg;
            out_ton_reg   <= ton_reg;
            out_lo_reg    <= lo_reg;
            out_hi_reg    <= hi_reg;
            out_mean_reg  <= mean_reg;
            out_fill_reg  <= fill_wide[FILL_W-1:0];
            out_count_reg <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_ton_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_fill_reg, out_mean_reg,
                       out_hi_reg, out_lo_reg, out_shown_reg};

    `WWS_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= DEPTH_C)
    `WWS_ASSERT_IMP(a_ptr_tracks_fill, aclk, aresetn, fill_reg != DEPTH_C,
                    wr_ptr_reg == fill_reg[PTR_W-1:0])
    `WWS_ASSERT_IMP(a_scan_nonempty, aclk, aresetn, state_reg == ST_SCAN, fill_reg != '0)
    `WWS_ASSERT_NXT(a_div_to_out, aclk, aresetn, state_reg == ST_DIV && div_stat.done,
                    state_reg == ST_OUT)
    `WWS_ASSERT_IMP(a_div_only_in_div, aclk, aresetn, div_stat.busy, state_reg == ST_DIV)

endmodule

`default_nettype wire

>>> tb/windowed_weight_statistics_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_weight_statistics_top_tb
// Streams weight readings and window clears through the block under every
// scale mode, predicts shown value, window min/max/mean, fill and reading
// number for each reading, and checks every result beat field by field.
// Sender bursts and receiver stalls are random; mode writes happen idle.
// ----------------------------------------------------------------------------
module windowed_weight_statistics_top_tb;
    import wws_pkg::*;

    localparam int WINDOW_DEPTH = DEPTH_DEFAULT;
    localparam int HALF_PERIOD  = 5;
    localparam int SETTLE       = 150;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 200;
    localparam int DIR_ROWS     = 24;

    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd0;

    typedef struct packed {
        logic [VALUE_W-1:0] shown;
        logic               ton;
        logic [VALUE_W-1:0] wmin;
        logic [VALUE_W-1:0] wmax;
        logic [VALUE_W-1:0] wmean;
        logic [FILL_W-1:0]  fill;
        logic [COUNT_W-1:0] number;
    } stats_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic                lit;
        stats_t              want;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_HOLD, RX_COIN, RX_MOSTLY} rx_kind_t;

    localparam stats_t NO_LIT = '0;

    localparam logic [SAMPLE_W-1:0] EDGE_VALS [4] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF
    };

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{MODE_KG, OP_READING, 24'h7FFFFF, 1'b1,
          '{25'h07FFFFF, 1'b0, 25'h07FFFFF, 25'h07FFFFF, 25'h07FFFFF, 7'd1, 32'd1}},
        '{MODE_KG, OP_READING, 24'h800000, 1'b1,
          '{25'h1800000, 1'b0, 25'h1800000, 25'h07FFFFF, 25'h0000000, 7'd2, 32'd2}},
        '{MODE_KG, OP_CLEAR, 24'h000000, 1'b0, NO_LIT},
        '{MODE_KG, OP_READING, 24'h000000, 1'b1,
          '{25'h0000000, 1'b0, 25'h0000000, 25'h0000000, 25'h0000000, 7'd1, 32'd3}},
        '{MODE_TON_X2, OP_CLEAR, 24'hFFFFFF, 1'b0, NO_LIT},
        '{MODE_TON_X2, OP_READING, 24'h7FFFFF, 1'b1,
          '{25'h0FFFFFE, 1'b1, 25'h0FFFFFE, 25'h0FFFFFE, 25'h0FFFFFE, 7'd1, 32'd4}},
        '{MODE_TON_X2, OP_READING, 24'h800000, 1'b1,
          '{25'h1000000, 1'b1, 25'h1000000, 25'h0FFFFFE, 25'h1FFFFFF, 7'd2, 32'd5}},
        '{MODE_TON_X2, OP_READING, 24'hFFFFFF, 1'b0, NO_LIT},
        '{MODE_TON_X2, OP_READING, 24'h000001, 1'b0, NO_LIT},
        '{MODE_TON,    OP_READING, 24'h000100, 1'b0, NO_LIT},
        '{MODE_TON,    OP_READING, 24'hFFFF00, 1'b0, NO_LIT},
        '{MODE_TON,    OP_READING, 24'h7FFFFF, 1'b0, NO_LIT},
        '{MODE_UNDEF,  OP_READING, 24'h7FFFFF, 1'b0, NO_LIT},
        '{MODE_UNDEF,  OP_READING, 24'h800000, 1'b0, NO_LIT},
        '{MODE_UNDEF,  OP_CLEAR,   24'h5A5A5A, 1'b0, NO_LIT},
        '{MODE_UNDEF,  OP_READING, 24'h123456, 1'b0, NO_LIT},
        '{MODE_KG,     OP_READING, 24'h555555, 1'b0, NO_LIT},
        '{MODE_KG,     OP_READING, 24'hAAAAAA, 1'b0, NO_LIT},
        '{MODE_KG,     OP_CLEAR,   24'h000000, 1'b0, NO_LIT},
        '{MODE_KG,     OP_CLEAR,   24'hFFFFFF, 1'b0, NO_LIT},
        '{MODE_KG,     OP_READING, 24'h000005, 1'b0, NO_LIT},
        '{MODE_KG,     OP_READING, 24'hFFFFF9, 1'b0, NO_LIT},
        '{MODE_KG,     OP_READING, 24'hFFFFFF, 1'b0, NO_LIT},
        '{MODE_KG,     OP_READING, 24'h000002, 1'b0, NO_LIT}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MODE_W-1:0]    cfg_data  = '0;

    // predictor state
    logic signed [VALUE_W-1:0] window_hist [WINDOW_DEPTH];
    int                        win_ptr       = 0;
    int                        win_fill      = 0;
    logic [COUNT_W-1:0]        reading_total = '0;
    logic [MODE_W-1:0]         mode_now      = MODE_KG;

    stats_t   stats_due [$];
    int       mismatches = 0;
    int       burst_left = 0;
    int       quiet      = 0;
    rx_kind_t rx_kind    = RX_OPEN;
    int       rx_left    = 0;

    windowed_weight_statistics_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic stats_t weigh_reading(input logic [SAMPLE_W-1:0] raw);
        stats_t                    r;
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        longint                    acc;
        v = (mode_now == MODE_TON_X2) ? {raw, 1'b0} : {raw[SAMPLE_W-1], raw};
        window_hist[win_ptr] = v;
        win_ptr = (win_ptr == WINDOW_DEPTH - 1) ? 0 : win_ptr + 1;
        if (win_fill < WINDOW_DEPTH) begin
            win_fill++;
        end
        reading_total = reading_total + 1'b1;
        lo  = window_hist[0];
        hi  = window_hist[0];
        acc = 0;
        for (int i = 0; i < win_fill; i++) begin
            if (window_hist[i] < lo) begin
                lo = window_hist[i];
            end
            if (window_hist[i] > hi) begin
                hi = window_hist[i];
            end
            acc += window_hist[i];
        end
        r.shown  = v;
        r.ton    = (mode_now != MODE_KG);
        r.wmin   = lo;
        r.wmax   = hi;
        r.wmean  = VALUE_W'(acc / longint'(win_fill));
        r.fill   = FILL_W'(win_fill);
        r.number = reading_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_stats_beat;
        stats_t want;
        if (stats_due.size() == 0) begin
            report_mismatch("result beat with nothing due, shown_value",
                            32'(m_tdata[24:0]), 32'd0);
            return;
        end
        want = stats_due.pop_front();
        if (m_tdata[24:0] != want.shown)
            report_mismatch("shown_value", 32'(m_tdata[24:0]), 32'(want.shown));
        if (m_tuser != want.ton)
            report_mismatch("unit_is_ton", 32'(m_tuser), 32'(want.ton));
        if (m_tdata[49:25] != want.wmin)
            report_mismatch("window_minimum", 32'(m_tdata[49:25]), 32'(want.wmin));
        if (m_tdata[74:50] != want.wmax)
            report_mismatch("window_maximum", 32'(m_tdata[74:50]), 32'(want.wmax));
        if (m_tdata[99:75] != want.wmean)
            report_mismatch("window_mean", 32'(m_tdata[99:75]), 32'(want.wmean));
        if (m_tdata[106:100] != want.fill)
            report_mismatch("window_fill", 32'(m_tdata[106:100]), 32'(want.fill));
        if (m_tdata[138:107] != want.number)
            report_mismatch("reading_number", m_tdata[138:107], want.number);
        if (m_tdata[M_TDATA_W-1:139] != '0)
            report_mismatch("tdata padding", 32'(m_tdata[M_TDATA_W-1:139]), 32'd0);
    endtask

    // idle the sender, drain the results, then write the mode
    task automatic write_mode(input logic [MODE_W-1:0] m);
        s_tvalid   <= 1'b0;
        burst_left  = 0;
        while (stats_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_now   = m;
    endtask

    task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] smp,
                             input logic lit, input stats_t lit_want);
        stats_t due;
        int     gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (op == OP_CLEAR) begin
            win_ptr  = 0;
            win_fill = 0;
        end else begin
            due = weigh_reading(smp);
            stats_due.push_back(lit ? lit_want : due);
        end
    endtask

    // result side: check, then pick the next stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_stats_beat();
        end
        if (rx_left == 0) begin
            rx_kind = rx_kind_t'($urandom_range(0, 3));
            rx_left = (rx_kind == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(1, 80);
        end else begin
            rx_left--;
        end
        case (rx_kind)
            RX_OPEN:   m_tready <= 1'b1;
            RX_HOLD:   m_tready <= 1'b0;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:   m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (quiet >= QUIET_LIMIT) begin
            $display("windowed_weight_statistics_top test failed");
            $finish;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        logic                op;
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0] mag;
        logic [MODE_W-1:0]   m;
        int                  clear_odds;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].mode != mode_now) begin
                write_mode(DIR_TABLE[r].mode);
            end
            send_beat(DIR_TABLE[r].op, DIR_TABLE[r].sample, DIR_TABLE[r].lit,
                      DIR_TABLE[r].want);
        end

        // even phases run long enough to fill and wrap the window
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            m = (ph == 0) ? MODE_TON_X2 : MODE_W'($urandom_range(0, 3));
            write_mode(m);
            clear_odds = (ph % 2 == 0) ? 400 : 8;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(1, clear_odds) == 1) ? OP_CLEAR : OP_READING;
                case ($urandom_range(0, 9))
                    0: begin
                        smp = EDGE_VALS[$urandom_range(0, 3)];
                    end
                    1, 2, 3: begin
                        mag = SAMPLE_W'($urandom_range(0, 4095));
                        smp = ($urandom_range(0, 1) == 1) ? -mag : mag;
                    end
                    default: begin
                        smp = SAMPLE_W'($urandom);
                    end
                endcase
                send_beat(op, smp, 1'b0, NO_LIT);
            end
        end

        s_tvalid <= 1'b0;
        while (stats_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("windowed_weight_statistics_top test passed");
        end else begin
            $display("windowed_weight_statistics_top test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/wws_pkg.sv
sv/wws_window_ram.sv
sv/wws_divider.sv
sv/windowed_weight_statistics_top.sv
tb/windowed_weight_statistics_top_tb.sv
